// ===== hdl/stft_pkg.sv =====
// shared types and constants of the windowed stft engine
package stft_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int WORK_BITS    = 24;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_XY_W  = 43;
   localparam int CORDIC_Z_W   = 27;
   localparam int ANGLE_W      = 25;
   localparam int HALF_TURN    = 16777216;
   localparam int CORDIC_GAIN  = 652032874;
   localparam int SQ_W         = 48;

   // register indexes of the configuration port
   localparam logic CSR_WINDOW_LENGTH = 1'b0;
   localparam logic CSR_HOP_LENGTH    = 1'b1;

   // request to the shared cordic unit
   typedef struct packed {
      logic                          start;
      logic                          vector_mode;
      logic signed [CORDIC_XY_W-1:0] x;
      logic signed [CORDIC_XY_W-1:0] y;
      logic signed [CORDIC_Z_W-1:0]  z;
   } cordic_req_type;

   // status and result of the cordic unit
   typedef struct packed {
      logic                          busy;
      logic                          done;
      logic signed [CORDIC_XY_W-1:0] x;
      logic signed [CORDIC_XY_W-1:0] y;
      logic signed [CORDIC_Z_W-1:0]  z;
   } cordic_rsp_type;

endpackage

// ===== hdl/stft_ram.sv =====
// generic single-write single-read ram with registered read data
module stft_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/stft_cordic.sv =====
// iterative cordic, rotation or vectoring mode, one step per cycle
module stft_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  stft_pkg::cordic_req_type req,
   output stft_pkg::cordic_rsp_type rsp
);
   import stft_pkg::*;

   logic signed [CORDIC_XY_W-1:0] x_ff, y_ff, x_in, y_in, xs, ys;
   logic signed [CORDIC_Z_W-1:0]  z_ff, z_in, at;
   logic [3:0]                    step_ff;
   logic                          mode_ff, busy_ff, done_ff, pos;

   // arctangent of 2^-i, 2^24 units per pi
   function automatic logic signed [CORDIC_Z_W-1:0] atan_unit(input logic [3:0] i);
      case (i)
         4'd0:    atan_unit = 27'sd4194304;
         4'd1:    atan_unit = 27'sd2476042;
         4'd2:    atan_unit = 27'sd1308273;
         4'd3:    atan_unit = 27'sd664100;
         4'd4:    atan_unit = 27'sd333339;
         4'd5:    atan_unit = 27'sd166832;
         4'd6:    atan_unit = 27'sd83436;
         4'd7:    atan_unit = 27'sd41721;
         4'd8:    atan_unit = 27'sd20861;
         4'd9:    atan_unit = 27'sd10430;
         4'd10:   atan_unit = 27'sd5215;
         4'd11:   atan_unit = 27'sd2608;
         4'd12:   atan_unit = 27'sd1304;
         4'd13:   atan_unit = 27'sd652;
         4'd14:   atan_unit = 27'sd326;
         default: atan_unit = 27'sd163;
      endcase
   endfunction

   // one micro-rotation
   always_comb begin
      pos = mode_ff ? y_ff[CORDIC_XY_W-1] : !z_ff[CORDIC_Z_W-1];
      xs  = x_ff >>> step_ff;
      ys  = y_ff >>> step_ff;
      at  = atan_unit(step_ff);
      x_in = pos ? x_ff - ys : x_ff + ys;
      y_in = pos ? y_ff + xs : y_ff - xs;
      z_in = pos ? z_ff - at : z_ff + at;
   end

   // step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 4'd1;
            if (step_ff == 4'(CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req.start) begin
         x_ff    <= req.x;
         y_ff    <= req.y;
         z_ff    <= req.z;
         mode_ff <= req.vector_mode;
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.x    = x_ff;
   assign rsp.y    = y_ff;
   assign rsp.z    = z_ff;

endmodule

// ===== hdl/hann_windowed_stft_engine_top.sv =====
// top level of the hann windowed stft engine
// Audio samples are taken one per cycle while no frame is in work; a sample that
// completes a frame starts a run that holds off further samples until its last bin
// is built. The run time is set by the shared 16-step cordic (twiddles, window
// coefficients, phases) and the work memories, each with one write and one read
// port, with one butterfly at a time.
// MAX_FFT_POINTS must be a power of two. The work memories need no clearing pass
// after reset; each frame zeroes its N entries.
module hann_windowed_stft_engine_top #(
   parameter int MAX_FFT_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_value
   input  logic        req_tuser,   // [0] start_of_signal
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] bin_magnitude, [31:16] bin_phase, [36:32] bin_index
   output logic        rsp_tlast,   // last_bin
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data
);
   import stft_pkg::*;

   localparam int AW = $clog2(MAX_FFT_POINTS);
   localparam int WW = $clog2(MAX_FFT_POINTS + 1);
   localparam int CW = (WW > 7) ? WW : 7;
   localparam int SW = $clog2(AW + 1);

   localparam logic [4:0] S_IDLE = 5'd0,  S_DIV = 5'd1,   S_CLR = 5'd2,   S_WSTART = 5'd3,
                          S_WWAIT = 5'd4, S_WMUL = 5'd5,  S_WWR = 5'd6,   S_BSTART = 5'd7,
                          S_BRDB = 5'd8,  S_BRDA = 5'd9,  S_BWAIT = 5'd10, S_BM0 = 5'd11,
                          S_BM1 = 5'd12,  S_BM2 = 5'd13,  S_BM3 = 5'd14,  S_BWB = 5'd15,
                          S_BWA = 5'd16,  S_ORD = 5'd17,  S_OCAP = 5'd18, S_OSQ0 = 5'd19,
                          S_OSQ1 = 5'd20, S_OSTART = 5'd21, S_OWAIT = 5'd22, S_OEMIT = 5'd23;

   // registers
   logic [4:0]             state_ff, state_in;
   logic [6:0]             wl_ff;
   logic [11:0]            hop_ff;
   logic [AW-1:0]          head_ff, head_in;
   logic [WW-1:0]          filled_ff, filled_in, w_ff, w_in;
   logic [11:0]            cd_ff, cd_in;
   logic [SW-1:0]          bits_ff, bits_in, stage_ff, stage_in;
   logic [25:0]            quo_ff, quo_in, angq_ff, angq_in;
   logic [AW-1:0]          rem_ff, rem_in, angr_ff, angr_in;
   logic [4:0]             dcnt_ff, dcnt_in;
   logic [AW:0]            cnt_ff, cnt_in;
   logic signed [16:0]     c_ff, c_in, s_ff, s_in;
   logic                   flip_ff, flip_in;
   logic signed [33:0]     wprod_ff, wprod_in;
   logic signed [23:0]     br_ff, br_in, bi_ff, bi_in, ar_ff, ar_in, ai_ff, ai_in;
   logic signed [41:0]     accr_ff, accr_in, acci_ff, acci_in;
   logic [SQ_W-1:0]        sq_ff, sq_in, iv_ff, iv_in, ir_ff, ir_in, ib_ff, ib_in;
   logic [4:0]             icnt_ff, icnt_in;
   logic                   idone_ff, idone_in, cdone_ff;
   logic signed [26:0]     base_ff, base_in;
   logic                   zero_ff, zero_in;
   logic                   rv_ff, rv_in, last_ff, last_in;
   logic [15:0]            mag_ff, mag_in, ph_ff, ph_in;
   logic [4:0]             idx_ff, idx_in;

   // combinational helpers
   cordic_req_type         cordic_req;
   cordic_rsp_type         cordic_rsp;
   logic [CW-1:0]          wl_ext;
   logic [WW-1:0]          w_eff, filled_base;
   logic [SW-1:0]          bits_eff;
   logic [11:0]            cd_base, cd_dec;
   logic                   accept, due;
   logic [AW:0]            n_val, half_n, half, jj, a_addr, b_addr, pos_full, rev_full, rev;
   logic [AW:0]            ang_sum, dsum;
   logic [AW-1:0]          dd;
   logic [ANGLE_W-1:0]     ang_sel, tw_ang;
   logic signed [CORDIC_Z_W-1:0] red_z;
   logic                   red_flip;
   logic signed [15:0]     samp;
   logic signed [17:0]     hsub, hcoef;
   logic signed [16:0]     mul_a;
   logic signed [23:0]     mul_b, sq_x;
   logic signed [40:0]     mul_p;
   logic signed [47:0]     sq_p;
   logic signed [26:0]     tr, ti;
   logic signed [CORDIC_XY_W-1:0] vx0, vy0;
   logic [SQ_W:0]          itrial;
   logic [25:0]            mround, mshift;
   logic signed [27:0]     psum;
   logic                   ring_we, ring_re, wk_we, wk_re;
   logic [AW-1:0]          ring_raddr, wk_waddr, wk_raddr;
   logic [WORK_BITS-1:0]   wk_wre, wk_wim, wk_rre, wk_rim;
   logic [SAMPLE_BITS-1:0] ring_rdata;

   // round by 2^15 and clamp a cordic output to the unit range
   function automatic logic signed [16:0] unit_q15(input logic signed [CORDIC_XY_W-1:0] v);
      logic signed [CORDIC_XY_W-1:0] t;
      t = (v + 43'sd16384) >>> 15;
      if (t > 43'sd32768) unit_q15 = 17'sd32768;
      else if (t < -43'sd32768) unit_q15 = -17'sd32768;
      else unit_q15 = 17'(t);
   endfunction

   // saturate to the work word
   function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
      if (v > 28'sd8388607) sat24 = 24'sd8388607;
      else if (v < -28'sd8388608) sat24 = -24'sd8388608;
      else sat24 = 24'(v);
   endfunction

   // effective window, fft order and frame-due decision
   always_comb begin
      wl_ext = CW'(wl_ff);
      if (wl_ext < CW'(2)) w_eff = WW'(2);
      else if (wl_ext > CW'(MAX_FFT_POINTS)) w_eff = WW'(MAX_FFT_POINTS);
      else w_eff = WW'(wl_ext);
      bits_eff = SW'(AW);
      for (int b = AW; b >= 0; b--) begin
         if (((AW + 1)'(1) << b) >= (AW + 1)'(w_eff)) bits_eff = SW'(b);
      end
      accept      = req_tvalid && req_tready;
      filled_base = req_tuser ? '0 : filled_ff;
      cd_base     = req_tuser ? '0 : cd_ff;
      cd_dec      = (cd_base != 12'd0) ? cd_base - 12'd1 : 12'd0;
      due         = (filled_base < w_eff) ? (filled_base + 1'b1 == w_eff) : (cd_dec == 12'd0);
   end

   // address generation
   always_comb begin
      n_val    = (AW + 1)'(1) << bits_ff;
      half_n   = n_val >> 1;
      half     = (AW + 1)'(1) << stage_ff;
      jj       = cnt_ff & (half - 1'b1);
      a_addr   = ((cnt_ff >> stage_ff) << (stage_ff + 1'b1)) | jj;
      b_addr   = a_addr | half;
      tw_ang   = ANGLE_W'(0) - (ANGLE_W'(jj) << (5'd24 - 5'(stage_ff)));
      pos_full = {1'b0, head_ff} - (AW + 1)'(w_ff) + cnt_ff;
      rev_full = '0;
      for (int b = 0; b < AW; b++) begin
         rev_full[b] = cnt_ff[AW - 1 - b];
      end
      rev      = rev_full >> ((AW + 1)'(AW) - (AW + 1)'(bits_ff));
      dd       = AW'(w_ff - 1'b1);
      dsum     = {rem_ff, dcnt_ff == 5'd25};
      ang_sum  = {1'b0, angr_ff} + {1'b0, rem_ff};
   end

   // angle range reduction for the rotation cordic
   always_comb begin
      ang_sel  = (state_ff == S_WSTART) ? angq_ff[ANGLE_W-1:0] : tw_ang;
      red_z    = CORDIC_Z_W'({2'b00, ang_sel});
      red_flip = 1'b0;
      if (ang_sel >= 25'(HALF_TURN / 2) && ang_sel < 25'(3 * (HALF_TURN / 2))) begin
         red_z    = red_z - 27'sd16777216;
         red_flip = 1'b1;
      end else if (ang_sel >= 25'(3 * (HALF_TURN / 2))) begin
         red_z = red_z - 27'sd33554432;
      end
   end

   // arithmetic
   always_comb begin
      samp   = signed'(ring_rdata);
      hsub   = 18'sd32768 - 18'(c_ff);
      hcoef  = hsub >>> 1;
      mul_a  = (state_ff == S_BM0 || state_ff == S_BM2) ? c_ff : s_ff;
      mul_b  = (state_ff == S_BM0 || state_ff == S_BM3) ? br_ff : bi_ff;
      mul_p  = mul_a * mul_b;
      sq_x   = (state_ff == S_OSQ0) ? ar_ff : ai_ff;
      sq_p   = sq_x * sq_x;
      tr     = 27'((accr_ff + 42'sd16384) >>> 15);
      ti     = 27'((acci_ff + 42'sd16384) >>> 15);
      vx0    = CORDIC_XY_W'(ar_ff) <<< 16;
      vy0    = CORDIC_XY_W'(ai_ff) <<< 16;
      itrial = {1'b0, ir_ff} + {1'b0, ib_ff};
      mround = 26'(ir_ff[24:0]) + (26'd1 << (bits_ff - 1'b1));
      mshift = mround >> bits_ff;
      psum   = 28'(base_ff) + 28'(cordic_rsp.z) + 28'sd256;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;   head_in = head_ff;   filled_in = filled_ff; cd_in = cd_ff;
      w_in = w_ff;           bits_in = bits_ff;   stage_in = stage_ff;   quo_in = quo_ff;
      rem_in = rem_ff;       dcnt_in = dcnt_ff;   angq_in = angq_ff;     angr_in = angr_ff;
      cnt_in = cnt_ff;       c_in = c_ff;         s_in = s_ff;           flip_in = flip_ff;
      wprod_in = wprod_ff;   br_in = br_ff;       bi_in = bi_ff;         ar_in = ar_ff;
      ai_in = ai_ff;         accr_in = accr_ff;   acci_in = acci_ff;     sq_in = sq_ff;
      iv_in = iv_ff;         ir_in = ir_ff;       ib_in = ib_ff;         icnt_in = icnt_ff;
      idone_in = idone_ff;   base_in = base_ff;   zero_in = zero_ff;
      rv_in = rv_ff;         mag_in = mag_ff;     ph_in = ph_ff;         idx_in = idx_ff;
      last_in = last_ff;
      ring_we = 1'b0; ring_re = 1'b0; ring_raddr = pos_full[AW-1:0];
      wk_we = 1'b0; wk_re = 1'b0; wk_waddr = cnt_ff[AW-1:0]; wk_raddr = cnt_ff[AW-1:0];
      wk_wre = '0; wk_wim = '0;
      cordic_req.start = 1'b0; cordic_req.vector_mode = 1'b0;
      cordic_req.x = CORDIC_XY_W'(CORDIC_GAIN); cordic_req.y = '0; cordic_req.z = red_z;

      if (rv_ff && rsp_tready) rv_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ring_we = 1'b1;
               head_in = head_ff + 1'b1;
               if (filled_base < w_eff) begin
                  filled_in = filled_base + 1'b1;
                  cd_in     = cd_base;
               end else begin
                  filled_in = filled_base;
                  cd_in     = cd_dec;
               end
               if (due) begin
                  cd_in    = (hop_ff == 12'd0) ? 12'd1 : hop_ff;
                  w_in     = w_eff;
                  bits_in  = bits_eff;
                  rem_in   = '0;
                  quo_in   = '0;
                  dcnt_in  = 5'd25;
                  state_in = S_DIV;
               end
            end
         end
         // 2^25 divided by w-1, one quotient bit a cycle
         S_DIV: begin
            if (dsum >= {1'b0, dd}) begin
               rem_in = AW'(dsum - {1'b0, dd});
               quo_in = {quo_ff[24:0], 1'b1};
            end else begin
               rem_in = AW'(dsum);
               quo_in = {quo_ff[24:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 5'd1;
            if (dcnt_ff == 5'd0) begin
               angq_in  = '0;
               angr_in  = dd >> 1;
               cnt_in   = '0;
               state_in = S_CLR;
            end
         end
         // zero the padded frame
         S_CLR: begin
            wk_we = 1'b1;
            if (cnt_ff == n_val - 1'b1) begin
               cnt_in   = '0;
               state_in = S_WSTART;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         // windowing, one sample per coefficient
         S_WSTART: begin
            if (cnt_ff == (AW + 1)'(w_ff)) begin
               cnt_in   = '0;
               stage_in = '0;
               state_in = S_BSTART;
            end else begin
               cordic_req.start = 1'b1;
               flip_in  = red_flip;
               ring_re  = 1'b1;
               state_in = S_WWAIT;
            end
         end
         S_WWAIT: begin
            if (cdone_ff) begin
               c_in     = flip_ff ? -unit_q15(cordic_rsp.x) : unit_q15(cordic_rsp.x);
               state_in = S_WMUL;
            end
         end
         S_WMUL: begin
            wprod_in = samp * hcoef;
            state_in = S_WWR;
         end
         S_WWR: begin
            wk_we    = 1'b1;
            wk_waddr = rev[AW-1:0];
            wk_wre   = WORK_BITS'((wprod_ff + 34'sd16384) >>> 15);
            cnt_in   = cnt_ff + 1'b1;
            if (ang_sum >= {1'b0, dd}) begin
               angr_in = AW'(ang_sum - {1'b0, dd});
               angq_in = angq_ff + quo_ff + 26'd1;
            end else begin
               angr_in = AW'(ang_sum);
               angq_in = angq_ff + quo_ff;
            end
            state_in = S_WSTART;
         end
         // butterfly: twiddle, read b then a, four products, write b then a
         S_BSTART: begin
            cordic_req.start = 1'b1;
            flip_in  = red_flip;
            wk_re    = 1'b1;
            wk_raddr = b_addr[AW-1:0];
            state_in = S_BRDB;
         end
         S_BRDB: begin
            br_in    = signed'(wk_rre);
            bi_in    = signed'(wk_rim);
            wk_re    = 1'b1;
            wk_raddr = a_addr[AW-1:0];
            state_in = S_BRDA;
         end
         S_BRDA: begin
            ar_in    = signed'(wk_rre);
            ai_in    = signed'(wk_rim);
            state_in = S_BWAIT;
         end
         S_BWAIT: begin
            if (cdone_ff) begin
               c_in     = flip_ff ? -unit_q15(cordic_rsp.x) : unit_q15(cordic_rsp.x);
               s_in     = flip_ff ? -unit_q15(cordic_rsp.y) : unit_q15(cordic_rsp.y);
               state_in = S_BM0;
            end
         end
         S_BM0: begin
            accr_in  = 42'(mul_p);
            state_in = S_BM1;
         end
         S_BM1: begin
            accr_in  = accr_ff - 42'(mul_p);
            state_in = S_BM2;
         end
         S_BM2: begin
            acci_in  = 42'(mul_p);
            state_in = S_BM3;
         end
         S_BM3: begin
            acci_in  = acci_ff + 42'(mul_p);
            state_in = S_BWB;
         end
         S_BWB: begin
            wk_we    = 1'b1;
            wk_waddr = b_addr[AW-1:0];
            wk_wre   = sat24(28'(ar_ff) - 28'(tr));
            wk_wim   = sat24(28'(ai_ff) - 28'(ti));
            state_in = S_BWA;
         end
         S_BWA: begin
            wk_we    = 1'b1;
            wk_waddr = a_addr[AW-1:0];
            wk_wre   = sat24(28'(ar_ff) + 28'(tr));
            wk_wim   = sat24(28'(ai_ff) + 28'(ti));
            state_in = S_BSTART;
            if (cnt_ff == half_n - 1'b1) begin
               cnt_in = '0;
               if (stage_ff == bits_ff - 1'b1) state_in = S_ORD;
               else stage_in = stage_ff + 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         // output bins: magnitude by isqrt, phase by vectoring cordic
         S_ORD: begin
            wk_re    = 1'b1;
            state_in = S_OCAP;
         end
         S_OCAP: begin
            ar_in    = signed'(wk_rre);
            ai_in    = signed'(wk_rim);
            state_in = S_OSQ0;
         end
         S_OSQ0: begin
            sq_in    = unsigned'(sq_p);
            state_in = S_OSQ1;
         end
         S_OSQ1: begin
            sq_in = sq_ff + unsigned'(sq_p);
            cordic_req.start       = 1'b1;
            cordic_req.vector_mode = 1'b1;
            cordic_req.z           = '0;
            cordic_req.x           = ar_ff[23] ? -vx0 : vx0;
            cordic_req.y           = ar_ff[23] ? -vy0 : vy0;
            zero_in = (ar_ff == 24'sd0) && (ai_ff == 24'sd0);
            if (ar_ff[23]) base_in = ai_ff[23] ? -27'sd16777216 : 27'sd16777216;
            else base_in = '0;
            state_in = S_OSTART;
         end
         S_OSTART: begin
            iv_in    = sq_ff;
            ir_in    = '0;
            ib_in    = SQ_W'(1) << 46;
            icnt_in  = '0;
            idone_in = 1'b0;
            state_in = S_OWAIT;
         end
         S_OWAIT: begin
            if (!idone_ff) begin
               if ({1'b0, iv_ff} >= itrial) begin
                  iv_in = iv_ff - SQ_W'(itrial);
                  ir_in = (ir_ff >> 1) + ib_ff;
               end else begin
                  ir_in = ir_ff >> 1;
               end
               ib_in   = ib_ff >> 2;
               icnt_in = icnt_ff + 5'd1;
               if (icnt_ff == 5'd23) idone_in = 1'b1;
            end else if (cdone_ff) begin
               state_in = S_OEMIT;
            end
         end
         S_OEMIT: begin
            if (!rv_ff || rsp_tready) begin
               rv_in   = 1'b1;
               mag_in  = (mshift > 26'd65535) ? 16'hFFFF : mshift[15:0];
               ph_in   = zero_ff ? 16'd0 : 16'(psum >>> 9);
               idx_in  = 5'(cnt_ff);
               last_in = (cnt_ff == half_n - 1'b1);
               if (cnt_ff == half_n - 1'b1) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_ORD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wl_ff     <= 7'd64;
         hop_ff    <= 12'd32;
         head_ff   <= '0;
         filled_ff <= '0;
         cd_ff     <= '0;
         rv_ff     <= 1'b0;
         cdone_ff  <= 1'b0;
         idone_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         filled_ff <= filled_in;
         cd_ff     <= cd_in;
         rv_ff     <= rv_in;
         idone_ff  <= idone_in;
         if (cordic_req.start) cdone_ff <= 1'b0;
         else if (cordic_rsp.done) cdone_ff <= 1'b1;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_LENGTH: wl_ff  <= csr_data[6:0];
               default:           hop_ff <= csr_data;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      w_ff <= w_in;       bits_ff <= bits_in;   stage_ff <= stage_in; quo_ff <= quo_in;
      rem_ff <= rem_in;   dcnt_ff <= dcnt_in;   angq_ff <= angq_in;   angr_ff <= angr_in;
      cnt_ff <= cnt_in;   c_ff <= c_in;         s_ff <= s_in;         flip_ff <= flip_in;
      wprod_ff <= wprod_in; br_ff <= br_in;     bi_ff <= bi_in;       ar_ff <= ar_in;
      ai_ff <= ai_in;     accr_ff <= accr_in;   acci_ff <= acci_in;   sq_ff <= sq_in;
      iv_ff <= iv_in;     ir_ff <= ir_in;       ib_ff <= ib_in;       icnt_ff <= icnt_in;
      base_ff <= base_in; zero_ff <= zero_in;   mag_ff <= mag_in;     ph_ff <= ph_in;
      idx_ff <= idx_in;   last_ff <= last_in;
   end

   // memories and shared cordic
   stft_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FFT_POINTS)) u_ring (
      .clock(clock), .wr_en(ring_we), .wr_addr(head_ff), .wr_data(req_tdata),
      .rd_en(ring_re), .rd_addr(ring_raddr), .rd_data(ring_rdata)
   );

   stft_ram #(.WIDTH(WORK_BITS), .DEPTH(MAX_FFT_POINTS)) u_work_re (
      .clock(clock), .wr_en(wk_we), .wr_addr(wk_waddr), .wr_data(wk_wre),
      .rd_en(wk_re), .rd_addr(wk_raddr), .rd_data(wk_rre)
   );

   stft_ram #(.WIDTH(WORK_BITS), .DEPTH(MAX_FFT_POINTS)) u_work_im (
      .clock(clock), .wr_en(wk_we), .wr_addr(wk_waddr), .wr_data(wk_wim),
      .rd_en(wk_re), .rd_addr(wk_raddr), .rd_data(wk_rim)
   );

   stft_cordic u_cordic (
      .clock(clock), .reset(reset), .req(cordic_req), .rsp(cordic_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {3'b000, idx_ff, ph_ff, mag_ff};
   assign rsp_tlast  = last_ff;

   // the cordic is never restarted while it iterates
   assert property (@(posedge clock) disable iff (reset)
      cordic_req.start |-> !cordic_rsp.busy) else $error("cordic restarted while busy");

   // the clearing pass stays inside the padded frame
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> (cnt_ff < n_val)) else $error("clear address out of frame");

   // butterflies only run on stages below the fft order
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BWA) |-> (stage_ff < bits_ff)) else $error("butterfly stage overrun");

   // the last bin of a frame carries the top bin number
   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && last_ff) |-> (idx_ff == 5'(half_n - 1'b1))) else $error("last bin misplaced");

endmodule

// ===== test/hann_windowed_stft_engine_top_test.sv =====
// self-checking testbench of the hann windowed stft engine
`timescale 1ns / 100ps

module hann_windowed_stft_engine_top_test;
   import stft_pkg::*;

   localparam int  RING_DEPTH  = 64;
   localparam int  CYCLE_LIMIT = 3000000;
   localparam longint HALF     = 64'd16777216;
   localparam longint GAIN_Q30 = 64'd652032874;

   // one spectrum bin as it leaves the block
   typedef struct packed {
      logic [15:0] magnitude;
      logic [15:0] phase;
      logic [4:0]  index;
      logic        last;
   } spectrum_bin_type;

   // one row of the directed stimulus
   typedef struct packed {
      logic [15:0] sample;
      logic        restart;
      logic        typed;   // expected bins are known zero bins
   } sample_row_type;

   // one setting of the registers, the number of samples run under it and the restart odds
   typedef struct packed {
      logic [6:0]  window;
      logic [11:0] hop;
      int          count;
      int          restart_odds;
   } stream_phase_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [11:0] csr_data;

   // model of the engine's state
   int unsigned      window_reg;
   int unsigned      hop_reg;
   longint           audio_ring [RING_DEPTH];
   int unsigned      ring_head;
   int unsigned      hop_left;
   int unsigned      fill_count;
   longint           spec_re [RING_DEPTH];
   longint           spec_im [RING_DEPTH];
   longint           hann_coef [RING_DEPTH];
   spectrum_bin_type bins_due [$];

   int          mismatches;
   int unsigned cycle_count;
   int          burst_left;

   const longint arctan_step [16] = '{
      4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
      20861, 10430, 5215, 2608, 1304, 652, 326, 163};

   hann_windowed_stft_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // rounding shift, half up
   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_q15(input longint v);
      if (v > 32768) return 32768;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint sat_work(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // rotation cordic, angle in 2^25 units per turn, results in q15
   task automatic rotate_unit(input logic [31:0] angle, output longint c, output longint s);
      longint z, x, y, nx;
      bit     flip;
      z    = longint'(angle[24:0]);
      flip = 1'b0;
      x    = GAIN_Q30;
      y    = 0;
      if (z >= HALF / 2 && z < 3 * (HALF / 2)) begin
         z    = z - HALF;
         flip = 1'b1;
      end else if (z >= 3 * (HALF / 2)) begin
         z = z - 2 * HALF;
      end
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - arctan_step[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + arctan_step[i];
         end
         x = nx;
      end
      c = clamp_q15(round_shift(x, 15));
      s = clamp_q15(round_shift(y, 15));
      if (flip) begin
         c = -c;
         s = -s;
      end
   endtask

   // vectoring cordic, 32768 units per half turn
   function automatic longint bin_angle(input longint re, input longint im);
      longint x, y, z, base, nx;
      x    = re * 65536;
      y    = im * 65536;
      z    = 0;
      base = 0;
      if (re == 0 && im == 0) return 0;
      if (x < 0) begin
         x    = -x;
         y    = -y;
         base = (im >= 0) ? HALF : -HALF;
      end
      for (int i = 0; i < 16; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + arctan_step[i];
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - arctan_step[i];
         end
         x = nx;
      end
      return round_shift(base + z, 9);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // window, transform and queue the bins of one frame
   task automatic transform_frame(input int unsigned w);
      int unsigned      n, bits, rev, pos, half, stride;
      longint           c, s, tr, ti, ar, ai, re, im, v;
      longint unsigned  mag;
      logic [31:0]      ang;
      spectrum_bin_type bin;
      n    = 1;
      bits = 0;
      while (n < w) begin
         n = n << 1;
         bits++;
      end
      for (int i = 0; i < w; i++) begin
         ang = 32'((((64'(i)) << 25) + (w - 1) / 2) / (w - 1));
         rotate_unit(ang, c, s);
         hann_coef[i] = (32768 - c) / 2;
      end
      for (int i = 0; i < n; i++) begin
         rev = 0;
         for (int b = 0; b < bits; b++)
            if (i & (1 << b)) rev = rev | (1 << (bits - 1 - b));
         v = 0;
         if (rev < w) begin
            pos = (ring_head + RING_DEPTH - w + rev) % RING_DEPTH;
            v   = round_shift(audio_ring[pos] * hann_coef[rev], 15);
         end
         spec_re[i] = v;
         spec_im[i] = 0;
      end
      for (int size = 2; size <= n; size = size << 1) begin
         half   = size / 2;
         stride = n / size;
         for (int blk = 0; blk < n; blk += size) begin
            for (int j = 0; j < half; j++) begin
               ang = 32'd0 - 32'(j * stride * (1 << (25 - bits)));
               rotate_unit(ang, c, s);
               tr = round_shift(c * spec_re[blk+j+half] - s * spec_im[blk+j+half], 15);
               ti = round_shift(c * spec_im[blk+j+half] + s * spec_re[blk+j+half], 15);
               ar = spec_re[blk+j];
               ai = spec_im[blk+j];
               spec_re[blk+j+half] = sat_work(ar - tr);
               spec_im[blk+j+half] = sat_work(ai - ti);
               spec_re[blk+j]      = sat_work(ar + tr);
               spec_im[blk+j]      = sat_work(ai + ti);
            end
         end
      end
      for (int i = 0; i < n / 2; i++) begin
         re  = spec_re[i];
         im  = spec_im[i];
         mag = int_sqrt(longint'(re * re) + longint'(im * im));
         mag = (mag + n / 2) >> bits;
         if (mag > 65535) mag = 65535;
         bin.magnitude = mag[15:0];
         bin.phase     = 16'(bin_angle(re, im));
         bin.index     = 5'(i);
         bin.last      = (i == n / 2 - 1);
         bins_due.push_back(bin);
      end
   endtask

   // take one accepted sample into the model state
   task automatic predict_sample(input logic [15:0] sample, input logic restart,
                                 input logic typed);
      int unsigned w;
      bit          due;
      int          queued;
      w = window_reg;
      if (w < 2) w = 2;
      if (w > RING_DEPTH) w = RING_DEPTH;
      due = 1'b0;
      if (restart) begin
         fill_count = 0;
         hop_left   = 0;
      end
      audio_ring[ring_head] = longint'($signed(sample));
      ring_head = (ring_head + 1) % RING_DEPTH;
      if (fill_count < w) begin
         fill_count++;
         if (fill_count == w) due = 1'b1;
      end else begin
         if (hop_left > 0) hop_left--;
         if (hop_left == 0) due = 1'b1;
      end
      if (due) begin
         hop_left = (hop_reg != 0) ? hop_reg : 1;
         queued   = bins_due.size();
         transform_frame(w);
         // a two-sample window has zero weight at both ends
         if (typed)
            for (int i = queued; i < bins_due.size(); i++)
               bins_due[i] = '{magnitude: 16'd0, phase: 16'd0, index: 5'd0, last: 1'b1};
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatches++;
   endtask

   // one register write on the configuration channel, valid left high
   task automatic write_register(input logic index, input logic [11:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == CSR_WINDOW_LENGTH) window_reg = value[6:0];
      else hop_reg = value;
   endtask

   // registers change only once the block has drained
   task automatic set_registers(input logic [6:0] window, input logic [11:0] hop);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (bins_due.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      write_register(CSR_WINDOW_LENGTH, {5'd0, window});
      write_register(CSR_HOP_LENGTH, hop);
      csr_valid <= 1'b0;
   endtask

   // send one item, holding tvalid across a burst
   task automatic send_sample(input logic [15:0] sample, input logic restart,
                              input logic typed);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      predict_sample(sample, restart, typed);
   endtask

   // receiver: stretches of full speed alternate with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= cycle_count[10] ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // bin checker
   always @(posedge clock) begin
      spectrum_bin_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (bins_due.size() == 0) begin
            report_mismatch("unexpected bin", 1, 0);
         end else begin
            want = bins_due.pop_front();
            if (rsp_tdata[15:0] !== want.magnitude)
               report_mismatch("magnitude", rsp_tdata[15:0], want.magnitude);
            if (rsp_tdata[31:16] !== want.phase)
               report_mismatch("phase", $signed(rsp_tdata[31:16]), $signed(want.phase));
            if (rsp_tdata[36:32] !== want.index)
               report_mismatch("index", rsp_tdata[36:32], want.index);
            if (rsp_tlast !== want.last)
               report_mismatch("last", rsp_tlast, want.last);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hann_windowed_stft_engine_top_test: FAIL");
         $finish;
      end
   end

   sample_row_type   directed_rows [$];
   stream_phase_type random_phases [$];

   initial begin
      logic [15:0] sample;
      logic        restart;
      cycle_count = 0;
      mismatches  = 0;
      burst_left  = 0;
      window_reg  = 64;
      hop_reg     = 32;
      ring_head   = 0;
      hop_left    = 0;
      fill_count  = 0;
      foreach (audio_ring[i]) audio_ring[i] = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_WINDOW_LENGTH;
      csr_data   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: two-sample windows, every frame all zero, field extremes
      directed_rows = '{
         '{16'h0000, 1'b1, 1'b1}, '{16'h7FFF, 1'b0, 1'b1}, '{16'h8000, 1'b0, 1'b1},
         '{16'hFFFF, 1'b0, 1'b1}, '{16'h0001, 1'b0, 1'b1}, '{16'h7FFF, 1'b1, 1'b1},
         '{16'h7FFF, 1'b0, 1'b1}, '{16'h8000, 1'b1, 1'b1}, '{16'h8000, 1'b0, 1'b1},
         '{16'h5555, 1'b0, 1'b1}, '{16'hAAAA, 1'b0, 1'b1}, '{16'h0000, 1'b0, 1'b1}};
      set_registers(7'd2, 12'd1);
      foreach (directed_rows[i])
         send_sample(directed_rows[i].sample, directed_rows[i].restart,
                     directed_rows[i].typed);

      // three-point window: reaches negative real bins with zero imaginary part
      set_registers(7'd3, 12'd1);
      send_sample(16'h8000, 1'b1, 1'b0);
      send_sample(16'h7FFF, 1'b0, 1'b0);
      send_sample(16'h8000, 1'b0, 1'b0);
      send_sample(16'h7FFF, 1'b0, 1'b0);

      // random stream under several register settings, clamped ones included
      random_phases = '{
         '{7'd0,   12'd0,    30, 20}, '{7'd5,  12'd3,    50, 20},
         '{7'd8,   12'd1,    40, 30}, '{7'd16, 12'd4095, 40, 8},
         '{7'd127, 12'd64,   70, 0},  '{7'd33, 12'd7,    40, 0}};
      foreach (random_phases[p]) begin
         set_registers(random_phases[p].window, random_phases[p].hop);
         for (int i = 0; i < random_phases[p].count; i++) begin
            sample  = 16'($urandom);
            restart = (i == 0) || (random_phases[p].restart_odds != 0 &&
                      $urandom_range(1, random_phases[p].restart_odds) == 1);
            send_sample(sample, restart, 1'b0);
         end
      end
      req_tvalid <= 1'b0;

      while (bins_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("hann_windowed_stft_engine_top_test: PASS");
      end else begin
         $display("hann_windowed_stft_engine_top_test: FAIL");
      end
      $finish;
   end

endmodule
